>>> hw/rtl/srdp_pkg.sv
// ----------------------------------------------------------------------------
// srdp_pkg
// Shared types and constants for the sparse row dot product block.
// ----------------------------------------------------------------------------
package srdp_pkg;

   localparam int INDEX_BITS      = 12;
   localparam int VALUE_PORT_BITS = 32;
   localparam int SUM_BITS        = 64;

   localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   // Request opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TERM = 1'b1;

   // Product of one row term, on its way into the accumulator
   typedef struct packed {
      logic                valid;
      logic                last;
      logic [SUM_BITS-1:0] prod;
   } term_type;

endpackage

>>> hw/rtl/srdp_ram.sv
// ----------------------------------------------------------------------------
// srdp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module srdp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/srdp_accum.sv
// ----------------------------------------------------------------------------
// srdp_accum
// Saturating Q32.32 accumulator and result register.
// ----------------------------------------------------------------------------
module srdp_accum (
   input  logic                               clock,
   input  logic                               reset,
   input  srdp_pkg::term_type                 term_in,
   output logic                               hold,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [srdp_pkg::SUM_BITS-1:0]      rsp_sum,
   output logic                               rsp_overflow
);

   import srdp_pkg::*;

   logic [SUM_BITS-1:0] acc_ff, acc_in;
   logic                sat_ff, sat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0] rsp_sum_ff, rsp_sum_in;
   logic                rsp_overflow_ff, rsp_overflow_in;

   logic [SUM_BITS:0]   wide_sum;
   logic                clamp;
   logic [SUM_BITS-1:0] sat_sum;
   logic                take;

   // Hold a finished row while the previous result is still waiting
   assign hold = term_in.valid && term_in.last && rsp_valid_ff && rsp_stall;
   assign take = term_in.valid && !hold;

   assign wide_sum = {acc_ff[SUM_BITS-1], acc_ff} + {term_in.prod[SUM_BITS-1], term_in.prod};
   assign clamp    = wide_sum[SUM_BITS] ^ wide_sum[SUM_BITS-1];
   assign sat_sum  = clamp ? (wide_sum[SUM_BITS] ? SUM_MIN : SUM_MAX)
                           : wide_sum[SUM_BITS-1:0];

   always_comb begin
      acc_in          = acc_ff;
      sat_in          = sat_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_sum_in      = rsp_sum_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (take) begin
         if (term_in.last) begin
            acc_in          = '0;
            sat_in          = 1'b0;
            rsp_valid_in    = 1'b1;
            rsp_sum_in      = sat_sum;
            rsp_overflow_in = sat_ff | clamp;
         end else begin
            acc_in = sat_sum;
            sat_in = sat_ff | clamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff      <= rsp_sum_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sum      = rsp_sum_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

>>> hw/rtl/sparse_row_dot_product_top.sv
// ----------------------------------------------------------------------------
// sparse_row_dot_product_top
// Dot product of one sparse row with a dense vector held in on-chip RAM.
// ----------------------------------------------------------------------------
// Load requests (opcode OP_LOAD) write one Q16.16 dense-vector entry; row-term
// requests (opcode OP_TERM) gather the entry at their column, multiply it by
// the term value and add the Q32.32 product into a saturating 64-bit sum. The
// term marked last returns the sum and an overflow flag and clears the sum;
// an empty row is sent as one zero term marked last. The block takes one
// request per cycle: a three-stage pipeline (RAM read, multiply, accumulate)
// with the vector RAM's registered read as the first stage; an accepted last
// term passes the gather register and the product register, and rsp_valid
// rises from the result register. A result sits in that output register;
// requests keep flowing while it waits, and req_stall rises only when a
// second last term reaches the accumulator before the first result is taken.
// Every column read by a term must have been loaded since reset; a load to an
// index at or past VECTOR_DEPTH is dropped and a term at such a column reads
// zero. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module sparse_row_dot_product_top #(
   parameter int VECTOR_DEPTH = 4096,
   parameter int VALUE_BITS   = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic [srdp_pkg::INDEX_BITS-1:0]       req_index,
   input  logic signed [srdp_pkg::VALUE_PORT_BITS-1:0] req_value,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [srdp_pkg::SUM_BITS-1:0]  rsp_sum,
   output logic                                  rsp_overflow
);

   import srdp_pkg::*;

   localparam int ADDR_BITS = $clog2(VECTOR_DEPTH);

   // Row term waiting for its vector entry to come out of the RAM
   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic                  in_range;
      logic [VALUE_BITS-1:0] value;
   } gather_type;

   gather_type              p1_ff, p1_in;
   term_type                p2_ff, p2_in;

   logic                    hold;
   logic                    advance;
   logic                    accept;
   logic [31:0]             index_wide;
   logic [ADDR_BITS-1:0]    addr;
   logic                    in_range;
   logic [VALUE_BITS-1:0]   ram_rd_data;
   logic signed [VALUE_BITS-1:0]   mul_a;
   logic signed [VALUE_BITS-1:0]   mul_b;
   logic signed [2*VALUE_BITS-1:0] mul_full;
   logic [SUM_BITS-1:0]     rsp_sum_raw;

   // Whole pipeline moves together; only the accumulator stage can block it
   assign advance   = !hold;
   assign req_stall = hold;
   assign accept    = req_valid && !req_stall;

   // Map the column onto the RAM address and flag columns past the store
   assign index_wide = 32'(req_index);
   assign addr       = index_wide[ADDR_BITS-1:0];
   assign in_range   = index_wide < 32'(VECTOR_DEPTH);

   // Vector store: write on a load, read every advancing cycle for a term
   srdp_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (VECTOR_DEPTH)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (accept && (req_opcode == OP_LOAD) && in_range),
      .wr_addr (addr),
      .wr_data (req_value[VALUE_BITS-1:0]),
      .rd_en   (advance),
      .rd_addr (addr),
      .rd_data (ram_rd_data)
   );

   // Stage 1: capture the term alongside the RAM read
   always_comb begin
      p1_in = p1_ff;
      if (advance) begin
         p1_in.valid    = accept && (req_opcode == OP_TERM);
         p1_in.last     = req_last;
         p1_in.in_range = in_range;
         p1_in.value    = req_value[VALUE_BITS-1:0];
      end
   end

   // Stage 2: multiply; a column past the store contributes zero
   assign mul_a    = p1_ff.value;
   assign mul_b    = p1_ff.in_range ? ram_rd_data : '0;
   assign mul_full = mul_a * mul_b;

   always_comb begin
      p2_in = p2_ff;
      if (advance) begin
         p2_in.valid = p1_ff.valid;
         p2_in.last  = p1_ff.last;
         p2_in.prod  = SUM_BITS'(mul_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.valid <= 1'b0;
         p2_ff.valid <= 1'b0;
      end else begin
         p1_ff.valid <= p1_in.valid;
         p2_ff.valid <= p2_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff.last     <= p1_in.last;
      p1_ff.in_range <= p1_in.in_range;
      p1_ff.value    <= p1_in.value;
      p2_ff.last     <= p2_in.last;
      p2_ff.prod     <= p2_in.prod;
   end

   // Stage 3: saturating accumulate and result register
   srdp_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .term_in      (p2_ff),
      .hold         (hold),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_sum      (rsp_sum_raw),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_sum = rsp_sum_raw;

`ifndef SYNTHESIS
   // A blocked pipeline must not lose or alter the term waiting for the RAM
   assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(p1_ff))
      else $error("gather stage changed while stalled");

   // A last term leaving the accumulator always produces a result
   assert property (@(posedge clock) disable iff (reset)
      p2_ff.valid && p2_ff.last && !hold |=> rsp_valid)
      else $error("last term did not produce a result");

   // A column past the store must contribute nothing
   assert property (@(posedge clock) disable iff (reset)
      advance && p1_ff.valid && !p1_ff.in_range |=> p2_ff.prod == '0)
      else $error("out-of-range column gave a nonzero product");
`endif

endmodule

>>> tb/sparse_row_dot_product_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_row_dot_product_top_test
// Self-checking bench for the sparse row dot product block. An initial block
// queues dense-vector loads and sparse rows. A clocked driver presents them
// with random gaps, and a clocked monitor stalls the result channel at random.
// Each accepted request updates a local copy of the vector store and of the
// saturating Q32.32 row sum. Every returned row is checked against the oldest
// predicted sum and overflow flag.
// ----------------------------------------------------------------------------
module sparse_row_dot_product_top_test;
   import srdp_pkg::*;

   localparam int ITEM_TARGET = 600;
   localparam int DEPTH       = 4096;
   localparam int TAIL_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_EVERY = 150;

   typedef struct {
      logic                               opcode;
      logic [INDEX_BITS-1:0]              index;
      logic signed [VALUE_PORT_BITS-1:0]  value;
      logic                               last;
      bit                                 drain;   // hold until every row is back
   } request_type;

   typedef struct {
      logic signed [SUM_BITS-1:0] sum;
      logic                       overflow;
   } row_result_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_valid  = 1'b0;
   logic                               req_stall;
   logic                               req_opcode = OP_LOAD;
   logic [INDEX_BITS-1:0]              req_index  = '0;
   logic signed [VALUE_PORT_BITS-1:0]  req_value  = '0;
   logic                               req_last   = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall  = 1'b0;
   logic signed [SUM_BITS-1:0]         rsp_sum;
   logic                               rsp_overflow;

   request_type    pending_requests[$];
   row_result_type expected_rows[$];

   // Local copy of the block's state
   logic signed [VALUE_PORT_BITS-1:0] vector_copy [DEPTH];
   longint                            row_sum     = 0;
   logic                              row_clamped = 1'b0;

   // Generator bookkeeping: terms only gather columns already loaded
   bit column_loaded [DEPTH];
   int loaded_columns[$];

   int          failures    = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap    = 0;
   int unsigned stall_left  = 0;
   bit          send_calm   = 1'b0;
   bit          stall_calm  = 1'b0;
   bit          tail_window = 1'b0;

   sparse_row_dot_product_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_index    (req_index),
      .req_value    (req_value),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_sum      (rsp_sum),
      .rsp_overflow (rsp_overflow)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Apply one accepted request to the local state; a last term closes the row.
   function automatic void accumulate_request(request_type r);
      longint         prod;
      longint         total;
      row_result_type done;
      if (r.opcode == OP_LOAD) begin
         // the last bit means nothing on a load
         if (int'(r.index) < DEPTH) vector_copy[r.index] = r.value;
         return;
      end
      prod = 0;
      if (int'(r.index) < DEPTH) begin
         prod = longint'(r.value) * longint'(vector_copy[r.index]);
      end
      total = row_sum + prod;
      // clamp on wraparound and carry on from the clamped value
      if (prod > 0 && total < row_sum) begin
         total       = SUM_MAX;
         row_clamped = 1'b1;
      end else if (prod < 0 && total > row_sum) begin
         total       = SUM_MIN;
         row_clamped = 1'b1;
      end
      row_sum = total;
      if (r.last) begin
         done.sum      = row_sum;
         done.overflow = row_clamped;
         expected_rows.push_back(done);
         row_sum     = 0;
         row_clamped = 1'b0;
      end
   endfunction

   // Queue one request; every so often mark one to wait for a full drain.
   function automatic void queue_request(logic op, int idx, logic [VALUE_PORT_BITS-1:0] val,
                                         logic lst);
      request_type r;
      r.opcode = op;
      r.index  = INDEX_BITS'(idx);
      r.value  = val;
      r.last   = lst;
      r.drain  = (pending_requests.size() % DRAIN_EVERY) == DRAIN_EVERY - 1;
      if (op == OP_LOAD && !column_loaded[idx]) begin
         column_loaded[idx] = 1'b1;
         loaded_columns.push_back(idx);
      end
      pending_requests.push_back(r);
   endfunction

   // Bias toward the extremes so that rows saturate now and then.
   function automatic logic [VALUE_PORT_BITS-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'h7FFF_FFFF;
      if (r < 30) return 32'h8000_0000;
      if (r < 50) return 32'(int'($urandom_range(0, 262143)) - 131072);
      return $urandom;
   endfunction

   function automatic int pick_column();
      return loaded_columns[$urandom_range(0, loaded_columns.size() - 1)];
   endfunction

   // Driver: hold a request until accepted, then idle a random gap.
   always @(posedge clock) begin
      request_type nxt;
      int unsigned r;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            accumulate_request('{req_opcode, req_index, req_value, req_last, 1'b0});
         end
         if (!req_valid || !req_stall) begin
            if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain && expected_rows.size() != 0)) begin
               nxt = pending_requests.pop_front();
               req_valid  <= 1'b1;
               req_opcode <= nxt.opcode;
               req_index  <= nxt.index;
               req_value  <= nxt.value;
               req_last   <= nxt.last;
               r = $urandom_range(0, 99);
               if (send_calm || r < 60) begin
                  send_gap <= 0;
               end else if (r < 92) begin
                  send_gap <= $urandom_range(1, 3);
               end else begin
                  send_gap <= $urandom_range(8, 40);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted row, then pick the next stall.
   always @(posedge clock) begin
      row_result_type want;
      int unsigned    r;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               $error("row result with none pending: sum %h overflow %b",
                      rsp_sum, rsp_overflow);
               failures++;
            end else begin
               want = expected_rows.pop_front();
               if (rsp_sum !== want.sum) begin
                  $error("sum: expected %h, actual %h", want.sum, rsp_sum);
                  failures++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %b, actual %b", want.overflow, rsp_overflow);
                  failures++;
               end
            end
         end
         if ($urandom_range(0, 199) == 0) stall_calm = !stall_calm;
         if (tail_window) begin
            // drop stalls so that any stray row shows up
            rsp_stall <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            r = $urandom_range(0, 99);
            if (stall_calm || r < 65) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall  <= 1'b1;
               stall_left <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("sparse_row_dot_product_top verification failed");
      $finish;
   end

   initial begin
      int unsigned choice;
      int          len;

      // Directed: extreme entries, a load marked last, both saturation
      // directions, an empty row, a clean row after a clamped one.
      queue_request(OP_LOAD, 0,       32'h7FFF_FFFF, 1'b0);
      queue_request(OP_LOAD, DEPTH-1, 32'h8000_0000, 1'b0);
      queue_request(OP_LOAD, 1,       32'h0000_0000, 1'b0);
      queue_request(OP_LOAD, 2,       32'hFFFF_FFFF, 1'b0);
      queue_request(OP_LOAD, 3,       32'h0001_0000, 1'b0);
      queue_request(OP_LOAD, 5,       32'h1234_5678, 1'b1);
      queue_request(OP_TERM, 0,       32'h7FFF_FFFF, 1'b0);
      queue_request(OP_TERM, 3,       32'h0001_0000, 1'b1);
      // two 2^62 products clamp high, then a small negative one pulls back
      queue_request(OP_TERM, DEPTH-1, 32'h8000_0000, 1'b0);
      queue_request(OP_TERM, DEPTH-1, 32'h8000_0000, 1'b0);
      queue_request(OP_TERM, 2,       32'h0000_0005, 1'b1);
      // three near -2^62 products clamp low
      queue_request(OP_TERM, 0,       32'h8000_0000, 1'b0);
      queue_request(OP_TERM, 0,       32'h8000_0000, 1'b0);
      queue_request(OP_TERM, 0,       32'h8000_0000, 1'b1);
      queue_request(OP_TERM, 1,       32'h0000_0000, 1'b1);
      queue_request(OP_TERM, 3,       32'h0001_0000, 1'b1);
      queue_request(OP_TERM, DEPTH-1, 32'h0000_0000, 1'b1);
      queue_request(OP_TERM, 5,       32'hFFFF_FFFF, 1'b1);

      // Random: mostly well-formed rows over loaded columns, some load bursts,
      // a few empty rows and one-term rows.
      while (pending_requests.size() < ITEM_TARGET) begin
         choice = $urandom_range(0, 99);
         if (choice < 25) begin
            repeat ($urandom_range(1, 8)) begin
               queue_request(OP_LOAD,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEPTH-1)
                                                         : $urandom_range(0, 63),
                             pick_value(), 1'($urandom_range(0, 1)));
            end
         end else if (choice < 30) begin
            queue_request(OP_TERM, pick_column(), 32'h0000_0000, 1'b1);
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
            for (int k = 0; k < len; k++) begin
               queue_request(OP_TERM, pick_column(), pick_value(), k == len - 1);
            end
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      tail_window = 1'b1;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("sparse_row_dot_product_top verification clean");
      end else begin
         $display("sparse_row_dot_product_top verification failed");
      end
      $finish;
   end

endmodule
